// ===== sv/shfp_pkg.sv =====
package shfp_pkg;

  localparam int unsigned MaxPayloadDef = 32;
  localparam int unsigned JobQDepthDef  = 2;

  localparam logic [7:0] SyncFirstRst  = 8'hAA;
  localparam logic [7:0] SyncSecondRst = 8'h55;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SYNC2,
    PH_LEN,
    PH_VER,
    PH_ACK,
    PH_SEQLO,
    PH_SEQHI,
    PH_MSGID,
    PH_DATA,
    PH_CHECK
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } back_state_e;

  // one finished frame (or error) handed from the parser to the emitter
  typedef struct packed {
    status_e     status;
    logic [7:0]  length;
    logic [7:0]  version;
    logic [7:0]  ack;
    logic [15:0] seq_num;
    logic [7:0]  msg_id;
  } job_t;

  // parser status toward the top level
  typedef struct packed {
    logic push;       // job written this cycle
    logic in_data;    // parser waits for payload bytes
  } front_stat_t;

  function automatic logic job_has_data(job_t j);
    return (j.status == ST_GOOD) && (j.length != 8'd0);
  endfunction

endpackage

// ===== sv/shfp_ram.sv =====
module shfp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/shfp_jobq.sv =====
module shfp_jobq #(
  parameter int unsigned Depth = shfp_pkg::JobQDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  shfp_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  output shfp_pkg::job_t job_o,
  input  logic           pop_i
);
  import shfp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slot_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= job_i;
    end
  end

endmodule

// ===== sv/shfp_front.sv =====
module shfp_front #(
  parameter int unsigned MaxPayload = shfp_pkg::MaxPayloadDef,
  parameter int unsigned AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  output shfp_pkg::front_stat_t stat_o,
  output shfp_pkg::job_t        job_o,
  output logic                  ram_we_o,
  output logic [AddrW-1:0]      ram_waddr_o,
  output logic [7:0]            ram_wdata_o
);
  import shfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [5:0]  count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  len_q, len_d, ver_q, ver_d, ack_q, ack_d, id_q, id_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  sync1_q, sync2_q;

  logic        sync_hit, too_long, in_range, sum_ok;
  logic [5:0]  count_inc;
  phase_e      restart_phase;
  logic [7:0]  restart_sum, sum_add;

  assign sync_hit      = (rx_byte_i == sync1_q);
  assign restart_phase = sync_hit ? PH_SYNC2 : PH_IDLE;
  assign restart_sum   = sync_hit ? rx_byte_i : 8'd0;
  assign sum_add       = sum_q + rx_byte_i;
  assign too_long      = ({1'b0, rx_byte_i} > 9'(MaxPayload));
  assign in_range      = ({1'b0, count_q} < 7'(MaxPayload));
  assign count_inc     = count_q + 6'd1;
  assign sum_ok        = (rx_byte_i == sum_q);

  // next state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sum_d   = sum_q;
    len_d   = len_q;
    ver_d   = ver_q;
    ack_d   = ack_q;
    seq_d   = seq_q;
    id_d    = id_q;
    if (accept_i) begin
      case (phase_q)
        PH_SYNC2: begin
          if (rx_byte_i == sync2_q) begin
            sum_d   = sum_add;
            phase_d = PH_LEN;
          end else begin
            phase_d = restart_phase;
            sum_d   = restart_sum;
            count_d = '0;
          end
        end
        PH_LEN: begin
          if (too_long) begin
            phase_d = restart_phase;
            sum_d   = restart_sum;
            count_d = '0;
          end else begin
            len_d   = rx_byte_i;
            sum_d   = sum_add;
            phase_d = PH_VER;
          end
        end
        PH_VER: begin
          ver_d   = rx_byte_i;
          sum_d   = sum_add;
          phase_d = PH_ACK;
        end
        PH_ACK: begin
          ack_d   = rx_byte_i;
          sum_d   = sum_add;
          phase_d = PH_SEQLO;
        end
        PH_SEQLO: begin
          seq_d   = {8'd0, rx_byte_i};
          sum_d   = sum_add;
          phase_d = PH_SEQHI;
        end
        PH_SEQHI: begin
          seq_d   = {rx_byte_i, seq_q[7:0]};
          sum_d   = sum_add;
          phase_d = PH_MSGID;
        end
        PH_MSGID: begin
          id_d    = rx_byte_i;
          sum_d   = sum_add;
          count_d = '0;
          phase_d = (len_q == 8'd0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          sum_d   = sum_add;
          count_d = count_inc;
          if ({2'b00, count_inc} >= len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (sum_ok) begin
            phase_d = PH_IDLE;
            sum_d   = 8'd0;
            count_d = '0;
          end else begin
            phase_d = restart_phase;
            sum_d   = restart_sum;
            count_d = '0;
          end
        end
        default: begin
          phase_d = restart_phase;
          sum_d   = restart_sum;
          count_d = '0;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    stat_o.push    = 1'b0;
    stat_o.in_data = (phase_q == PH_DATA);
    job_o.status   = ST_GOOD;
    job_o.length   = len_q;
    job_o.version  = ver_q;
    job_o.ack      = ack_q;
    job_o.seq_num  = seq_q;
    job_o.msg_id   = id_q;
    ram_we_o       = 1'b0;
    ram_waddr_o    = count_q[AddrW-1:0];
    ram_wdata_o    = rx_byte_i;
    if (accept_i) begin
      case (phase_q)
        PH_LEN: begin
          if (too_long) begin
            stat_o.push    = 1'b1;
            job_o.status   = ST_TOO_LONG;
            job_o.length   = rx_byte_i;
            job_o.version  = 8'd0;
            job_o.ack      = 8'd0;
            job_o.seq_num  = 16'd0;
            job_o.msg_id   = 8'd0;
          end
        end
        PH_DATA: begin
          ram_we_o = in_range;
        end
        PH_CHECK: begin
          stat_o.push  = 1'b1;
          job_o.status = sum_ok ? ST_GOOD : ST_BAD_SUM;
        end
        default: begin
          stat_o.push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      len_q   <= '0;
      ver_q   <= '0;
      ack_q   <= '0;
      seq_q   <= '0;
      id_q    <= '0;
      sync1_q <= SyncFirstRst;
      sync2_q <= SyncSecondRst;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      ver_q   <= ver_d;
      ack_q   <= ack_d;
      seq_q   <= seq_d;
      id_q    <= id_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SYNC_FIRST:  sync1_q <= cfg_wdata_i;
          CFG_SYNC_SECOND: sync2_q <= cfg_wdata_i;
          default:         sync1_q <= sync1_q;
        endcase
      end
    end
  end

endmodule

// ===== sv/shfp_back.sv =====
module shfp_back #(
  parameter int unsigned MaxPayload = shfp_pkg::MaxPayloadDef,
  parameter int unsigned AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  shfp_pkg::job_t   job_i,
  output logic             job_pop_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [7:0]       ram_rdata_i,
  output logic             done_o,
  input  logic             pop,
  output logic             empty,
  output logic [1:0]       status_o,
  output logic [7:0]       frame_length_o,
  output logic [7:0]       version_o,
  output logic [7:0]       ack_flag_o,
  output logic [15:0]      sequence_res_o,
  output logic [7:0]       message_id_o,
  output logic [4:0]       payload_index_o,
  output logic [7:0]       payload_byte_o,
  output logic             last_o
);
  import shfp_pkg::*;

  back_state_e st_q, st_d;
  job_t        cur_q;
  logic [5:0]  idx_q;
  logic        out_valid_q, out_valid_d;
  logic        out_free, is_data, last_emit;
  logic        load_hdr, load_data;

  // output register
  job_t        o_job_q;
  logic [4:0]  o_idx_q;
  logic [7:0]  o_byte_q;
  logic        o_last_q;

  assign out_free  = !out_valid_q || pop;
  assign is_data   = job_has_data(job_i);
  assign last_emit = ((8'(idx_q) + 8'd1) == cur_q.length);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE: begin
        if (job_valid_i && is_data) begin
          st_d = BK_READ;
        end
      end
      BK_READ: st_d = BK_EMIT;
      BK_EMIT: begin
        if (out_free) begin
          st_d = last_emit ? BK_IDLE : BK_READ;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_pop_o   = 1'b0;
    ram_re_o    = 1'b0;
    load_hdr    = 1'b0;
    load_data   = 1'b0;
    done_o      = 1'b0;
    ram_raddr_o = idx_q[AddrW-1:0];
    case (st_q)
      BK_IDLE: begin
        job_pop_o = job_valid_i && (is_data || out_free);
        load_hdr  = job_valid_i && !is_data && out_free;
      end
      BK_READ: ram_re_o = 1'b1;
      BK_EMIT: begin
        load_data = out_free;
        done_o    = out_free && last_emit;
      end
      default: job_pop_o = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_hdr || load_data) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_IDLE && job_pop_o && is_data) begin
      cur_q <= job_i;
      idx_q <= '0;
    end else if (load_data && !last_emit) begin
      idx_q <= idx_q + 6'd1;
    end
    if (load_hdr) begin
      o_job_q  <= job_i;
      o_idx_q  <= 5'd0;
      o_byte_q <= 8'd0;
      o_last_q <= 1'b1;
    end else if (load_data) begin
      o_job_q  <= cur_q;
      o_idx_q  <= idx_q[4:0];
      o_byte_q <= ram_rdata_i;
      o_last_q <= last_emit;
    end
  end

  assign empty           = !out_valid_q;
  assign status_o        = o_job_q.status;
  assign frame_length_o  = o_job_q.length;
  assign version_o       = o_job_q.version;
  assign ack_flag_o      = o_job_q.ack;
  assign sequence_res_o  = o_job_q.seq_num;
  assign message_id_o    = o_job_q.msg_id;
  assign payload_index_o = o_idx_q;
  assign payload_byte_o  = o_byte_q;
  assign last_o          = o_last_q;

endmodule

// ===== sv/sync_header_frame_parser.sv =====
// Input: one byte per cycle unless full; full rises while the job queue is full, or while
//   the parser sits in the payload and the previous frame's payload is still being
//   emitted. Error and empty-frame results go from the job queue to the output register;
//   each payload byte is read from RAM, then loaded, waiting while a result is unpopped.
// Reset: parser idle, sum and header fields zero, sync bytes 0xAA / 0x55,
//   queues empty; payload RAM is not cleared.
module sync_header_frame_parser #(
  parameter int unsigned MaxPayload = shfp_pkg::MaxPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [7:0]  frame_length_o,
  output logic [7:0]  version_o,
  output logic [7:0]  ack_flag_o,
  output logic [15:0] sequence_res_o,
  output logic [7:0]  message_id_o,
  output logic [4:0]  payload_index_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o
);
  import shfp_pkg::*;

  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  front_stat_t      fstat;
  job_t             fjob, qjob;
  logic             jobq_full, jobq_valid, jobq_pop;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             back_done, accept;
  logic             data_pend_q, data_pend_d;

  // payload RAM holds one frame: hold off payload bytes until it is drained
  assign full   = jobq_full || (fstat.in_data && data_pend_q);
  assign accept = push && !full;

  always_comb begin
    data_pend_d = data_pend_q;
    if (fstat.push && job_has_data(fjob)) begin
      data_pend_d = 1'b1;
    end else if (back_done) begin
      data_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_pend_q <= 1'b0;
    end else begin
      data_pend_q <= data_pend_d;
    end
  end

  shfp_front #(
    .MaxPayload(MaxPayload),
    .AddrW     (AddrW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .stat_o     (fstat),
    .job_o      (fjob),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata)
  );

  shfp_jobq #(
    .Depth(JobQDepthDef)
  ) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fstat.push),
    .job_i  (fjob),
    .full_o (jobq_full),
    .valid_o(jobq_valid),
    .job_o  (qjob),
    .pop_i  (jobq_pop)
  );

  shfp_ram #(
    .Width(8),
    .Depth(MaxPayload),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  shfp_back #(
    .MaxPayload(MaxPayload),
    .AddrW     (AddrW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (jobq_valid),
    .job_i          (qjob),
    .job_pop_o      (jobq_pop),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .done_o         (back_done),
    .pop            (pop),
    .empty          (empty),
    .status_o       (status_o),
    .frame_length_o (frame_length_o),
    .version_o      (version_o),
    .ack_flag_o     (ack_flag_o),
    .sequence_res_o (sequence_res_o),
    .message_id_o   (message_id_o),
    .payload_index_o(payload_index_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

  a_no_ram_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !data_pend_q)
    else $error("payload RAM written while a frame is being emitted");

  a_jobq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.push |-> !jobq_full)
    else $error("job pushed into a full queue");

  a_done_has_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_done |-> data_pend_q)
    else $error("emitter finished a payload frame that was never queued");

  a_one_data_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fstat.push && job_has_data(fjob)) |-> !data_pend_q)
    else $error("second payload frame queued while one is outstanding");

endmodule
